// ===== hw/rtl/edd_pkg.sv =====
// Shared types and constants for the RGB error diffusion dither block.
package edd_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int BANK_DEPTH  = MAX_WIDTH / 2;
   localparam int BANK_AW     = COL_W - 1;
   localparam int WIDTH_W     = 11;
   localparam int WIDTH_RESET = 640;
   localparam int PIX_W       = 8;
   localparam int ERR_W       = 9;
   localparam int ENTRY_W     = 3 * ERR_W;
   localparam int PROD_W      = 12;
   localparam int SUM_W       = 11;
   localparam int ON_LIMIT    = 128;
   localparam int PIX_MAX     = 255;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic             frame_start;
   } req_payload_type;

   typedef struct packed {
      logic red_on;
      logic green_on;
      logic blue_on;
   } rsp_payload_type;

   // Signed divide by 16 truncating toward zero.
   function automatic logic signed [ERR_W-1:0] div16_trunc(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = (p + (p[PROD_W-1] ? PROD_W'(15) : PROD_W'(0))) >>> 4;
      return q[ERR_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/error_diffusion_dither_rgb_unit.sv =====
// Streaming Floyd-Steinberg 1-bit-per-channel RGB dither, two-bank line buffer.
//
// Pixels enter in raster order on the req_ channel (valid/stall); frame_start
// marks the first pixel of a frame and restarts row and column. Each item
// gives one rsp_ item holding one bit per channel. csr_write_data sets the
// row width (0 acts as 1, above 1024 acts as 1024); write it only while idle.
// Throughput is one item per clock while neither rsp_stall nor the bank clear
// holds it. The line buffer is read into rd_even_ff/rd_odd_ff when an item is
// accepted, as the compute-stage registers load; the error update and output
// register load when the compute stage fires, where rsp_valid rises. The
// right-neighbour error loop closes inside the compute stage. The line buffer
// is split into even and odd column banks so the two writes at a row end land
// in different banks; a read that meets a same-cycle write to its entry is
// forwarded. After reset req_stall stays high while both banks are cleared
// one entry per cycle. When rsp_stall is high while rsp_valid is up, the output
// register holds, the compute stage fills and then req_stall rises; no item is lost.
module error_diffusion_dither_rgb_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  edd_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output edd_pkg::rsp_payload_type rsp_payload,
   input  logic                    csr_write_enable,
   input  logic [edd_pkg::WIDTH_W-1:0] csr_write_data
);
   import edd_pkg::*;

   // control
   logic [WIDTH_W-1:0]   width_ff;
   logic [COL_W-1:0]     col_ff;
   logic                 first_row_ff;
   logic                 clear_busy_ff;
   logic [BANK_AW-1:0]   clear_addr_ff;

   // compute stage
   logic                 s1_valid_ff;
   logic [PIX_W-1:0]     s1_pix_ff [3];
   logic [COL_W-1:0]     s1_x_ff;
   logic                 s1_last_ff;
   logic                 s1_first_ff;
   logic                 s1_fs_ff;
   logic                 byp_even_ff;
   logic                 byp_odd_ff;
   logic [ENTRY_W-1:0]   byp_even_data_ff;
   logic [ENTRY_W-1:0]   byp_odd_data_ff;

   logic signed [ERR_W-1:0] right_ff [3];
   logic signed [ERR_W-1:0] bp0_ff [3];
   logic signed [ERR_W-1:0] bp1_ff [3];

   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_payload_ff;

   // line buffer banks
   logic [ENTRY_W-1:0]   mem_even [BANK_DEPTH];
   logic [ENTRY_W-1:0]   mem_odd  [BANK_DEPTH];
   logic [ENTRY_W-1:0]   rd_even_ff;
   logic [ENTRY_W-1:0]   rd_odd_ff;

   logic                 accept;
   logic                 s1_fire;
   logic [WIDTH_W-1:0]   width_act;
   logic [COL_W-1:0]     x_new;
   logic                 last_new;
   logic                 first_new;
   logic [BANK_AW-1:0]   rd_addr;

   logic [COL_W-1:0]     xm1;
   logic                 en_prev;
   logic                 en_last;
   logic                 we_even;
   logic                 we_odd;
   logic [BANK_AW-1:0]   wa_even;
   logic [BANK_AW-1:0]   wa_odd;
   logic [ENTRY_W-1:0]   wd_even;
   logic [ENTRY_W-1:0]   wd_odd;
   logic [ENTRY_W-1:0]   prev_entry;
   logic [ENTRY_W-1:0]   last_entry;
   logic [ENTRY_W-1:0]   rd_entry;

   logic signed [ERR_W-1:0] right_in [3];
   logic signed [ERR_W-1:0] bp0_in [3];
   logic signed [ERR_W-1:0] bp1_in [3];
   logic [2:0]           on_bits;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_busy_ff || (s1_valid_ff && !s1_fire);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // column and row tracking ahead of the read
   always_comb begin
      if (width_ff == '0) begin
         width_act = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         width_act = WIDTH_W'(MAX_WIDTH);
      end else begin
         width_act = width_ff;
      end
      x_new     = req_payload.frame_start ? '0 : col_ff;
      last_new  = {1'b0, x_new} >= (width_act - WIDTH_W'(1));
      first_new = req_payload.frame_start || first_row_ff;
      rd_addr   = x_new[COL_W-1:1];
   end

   // error arithmetic, one channel per iteration
   always_comb begin
      logic [PIX_W-1:0]         pix;
      logic signed [ERR_W-1:0]  right_cur;
      logic signed [ERR_W-1:0]  bp0_cur;
      logic signed [ERR_W-1:0]  bp1_cur;
      logic signed [ERR_W-1:0]  store_cur;
      logic signed [SUM_W-1:0]  v;
      logic [PIX_W-1:0]         vc;
      logic                     on;
      logic signed [PROD_W-1:0] e;
      logic signed [ERR_W-1:0]  t3;
      logic signed [ERR_W-1:0]  t5;
      rd_entry = s1_x_ff[0] ? (byp_odd_ff ? byp_odd_data_ff : rd_odd_ff)
                            : (byp_even_ff ? byp_even_data_ff : rd_even_ff);
      prev_entry = '0;
      last_entry = '0;
      for (int c = 0; c < 3; c++) begin
         pix       = s1_pix_ff[c];
         right_cur = s1_fs_ff ? '0 : right_ff[c];
         bp0_cur   = s1_fs_ff ? '0 : bp0_ff[c];
         bp1_cur   = s1_fs_ff ? '0 : bp1_ff[c];
         store_cur = s1_first_ff ? '0 : $signed(rd_entry[c*ERR_W +: ERR_W]);
         v = $signed({3'b000, pix}) + SUM_W'(right_cur) + SUM_W'(store_cur);
         if (v < 0) begin
            vc = '0;
         end else if (v > SUM_W'(PIX_MAX)) begin
            vc = PIX_W'(PIX_MAX);
         end else begin
            vc = v[PIX_W-1:0];
         end
         on = vc > PIX_W'(ON_LIMIT);
         e  = on ? ($signed({4'b0000, vc}) - PROD_W'(PIX_MAX)) : $signed({4'b0000, vc});
         t3 = div16_trunc(e * PROD_W'(3));
         t5 = div16_trunc(e * PROD_W'(5));
         right_in[c] = div16_trunc(e * PROD_W'(7));
         bp1_in[c]   = div16_trunc(e);
         bp0_in[c]   = bp1_cur + t5;
         prev_entry[c*ERR_W +: ERR_W] = bp0_cur + t3;
         last_entry[c*ERR_W +: ERR_W] = bp0_in[c];
         on_bits[c] = on;
      end
   end

   // bank write ports; x-1 and x always fall in different banks
   always_comb begin
      xm1     = s1_x_ff - COL_W'(1);
      en_prev = s1_fire && (s1_x_ff != '0);
      en_last = s1_fire && s1_last_ff;
      if (clear_busy_ff) begin
         we_even = 1'b1;
         wa_even = clear_addr_ff;
         wd_even = '0;
         we_odd  = 1'b1;
         wa_odd  = clear_addr_ff;
         wd_odd  = '0;
      end else begin
         if (en_prev && !xm1[0]) begin
            we_even = 1'b1;
            wa_even = xm1[COL_W-1:1];
            wd_even = prev_entry;
         end else begin
            we_even = en_last && !s1_x_ff[0];
            wa_even = s1_x_ff[COL_W-1:1];
            wd_even = last_entry;
         end
         if (en_prev && xm1[0]) begin
            we_odd = 1'b1;
            wa_odd = xm1[COL_W-1:1];
            wd_odd = prev_entry;
         end else begin
            we_odd = en_last && s1_x_ff[0];
            wa_odd = s1_x_ff[COL_W-1:1];
            wd_odd = last_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we_even) begin
         mem_even[wa_even] <= wd_even;
      end
      if (accept) begin
         rd_even_ff <= mem_even[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_odd) begin
         mem_odd[wa_odd] <= wd_odd;
      end
      if (accept) begin
         rd_odd_ff <= mem_odd[rd_addr];
      end
   end

   // stage payload and read forwarding
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff[0]     <= req_payload.red_in;
         s1_pix_ff[1]     <= req_payload.green_in;
         s1_pix_ff[2]     <= req_payload.blue_in;
         s1_x_ff          <= x_new;
         s1_last_ff       <= last_new;
         s1_first_ff      <= first_new;
         s1_fs_ff         <= req_payload.frame_start;
         byp_even_ff      <= we_even && (wa_even == rd_addr);
         byp_odd_ff       <= we_odd && (wa_odd == rd_addr);
         byp_even_data_ff <= wd_even;
         byp_odd_data_ff  <= wd_odd;
      end
      if (s1_fire) begin
         rsp_payload_ff.red_on   <= on_bits[0];
         rsp_payload_ff.green_on <= on_bits[1];
         rsp_payload_ff.blue_on  <= on_bits[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_W'(WIDTH_RESET);
         col_ff        <= '0;
         first_row_ff  <= 1'b1;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            right_ff[c] <= '0;
            bp0_ff[c]   <= '0;
            bp1_ff[c]   <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            width_ff <= csr_write_data;
         end
         if (clear_busy_ff) begin
            clear_addr_ff <= clear_addr_ff + BANK_AW'(1);
            if (clear_addr_ff == BANK_AW'(BANK_DEPTH - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
         if (accept) begin
            col_ff       <= last_new ? '0 : x_new + COL_W'(1);
            first_row_ff <= last_new ? 1'b0 : first_new;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
            for (int c = 0; c < 3; c++) begin
               right_ff[c] <= s1_last_ff ? '0 : right_in[c];
               bp0_ff[c]   <= s1_last_ff ? '0 : bp0_in[c];
               bp1_ff[c]   <= s1_last_ff ? '0 : bp1_in[c];
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
